### rtl/pau_pkg.sv
`default_nettype none
package pau_pkg;

  localparam int WORD_W      = 32;
  localparam int SAMPLE_W    = 12;
  localparam int GAIN_W      = 5;
  localparam int WIN_W       = 24;
  localparam int LIMIT_W     = 48;
  localparam int COUNT_W     = 32;
  localparam int SQ_W        = 2 * SAMPLE_W - 1;
  localparam int ENERGY_BITS = 48;
  localparam int CMP_W       = (ENERGY_BITS > LIMIT_W) ? ENERGY_BITS : LIMIT_W;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W   = CFG_ADDR_W - CFG_IDX_LSB;

  typedef logic [WORD_W-1:0]          word_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        raw_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_AGC_ENABLE   = 3'd0;
  localparam cfg_idx_t REG_WINDOW_LEN   = 3'd1;
  localparam cfg_idx_t REG_LOW_LIMIT    = 3'd2;
  localparam cfg_idx_t REG_HIGH_LIMIT   = 3'd3;
  localparam cfg_idx_t REG_MIN_GAIN     = 3'd4;
  localparam cfg_idx_t REG_MAX_GAIN     = 3'd5;

  localparam logic [WIN_W-1:0]   RST_WINDOW_LEN = 24'd2000000;
  localparam logic [LIMIT_W-1:0] RST_LOW_LIMIT  = '0;
  localparam logic [LIMIT_W-1:0] RST_HIGH_LIMIT = '1;
  localparam gain_t              RST_MIN_GAIN   = 5'd0;
  localparam gain_t              RST_MAX_GAIN   = 5'd21;

  localparam sample_t RAIL_POS     = 12'sd2047;
  localparam sample_t RAIL_NEG     = -12'sd2047;
  localparam sample_t RAIL_NEG_MIN = -12'sd2048;

  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

endpackage
`default_nettype wire

### rtl/pau_in_if.sv
`default_nettype none
interface pau_in_if;
  logic               valid;
  logic               ready;
  pau_pkg::word_t     packed_word;
  logic               first_of_block;

  modport source (output valid, packed_word, first_of_block, input ready);
  modport sink   (input valid, packed_word, first_of_block, output ready);
endinterface
`default_nettype wire

### rtl/pau_out_if.sv
`default_nettype none
interface pau_out_if;
  logic               valid;
  logic               ready;
  pau_pkg::sample_t   sample;
  logic               overrange;
  pau_pkg::count_t    overrange_count;
  pau_pkg::count_t    since_overrange;
  pau_pkg::gain_t     gain_step;
  logic               gain_changed;
  logic               last;

  modport source (output valid, sample, overrange, overrange_count, since_overrange,
                  gain_step, gain_changed, last, input ready);
  modport sink   (input valid, sample, overrange, overrange_count, since_overrange,
                  gain_step, gain_changed, last, output ready);
endinterface
`default_nettype wire

### rtl/packed_adc_unpack_with_agc.sv
// Channel   | Direction | Payload                                         | Handshake
// in_chan   | in        | packed_word, first_of_block                     | valid/ready
// out_chan  | out       | sample, overrange, counts, gain_step, flags     | valid/ready
// APB       | in        | six registers, 64-bit data, 8-byte stride       | pready always high
//
// One sample leaves per cycle unless out_chan stalls, and a word holds two or three samples;
// the single output register, fed one sample at a time from the word buffer, sets that rate.
// A word's first sample goes from the word buffer via the square stage to the output register.
// Synchronous active-low reset clears the pipeline, the statistics and the registers.
// When out_chan is stalled the output and a full square stage hold; a new word is taken
// as soon as the last sample of the current word moves on.
`default_nettype none
module packed_adc_unpack_with_agc (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  pau_in_if.sink                                  in_chan,
  pau_out_if.source                               out_chan,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pau_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [pau_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [pau_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  localparam int EW  = pau_pkg::ENERGY_BITS;
  localparam int SW  = pau_pkg::SAMPLE_W;

  // Configuration registers
  logic                            agc_en_r;
  logic [pau_pkg::WIN_W-1:0]       win_len_r;
  logic [pau_pkg::LIMIT_W-1:0]     low_lim_r;
  logic [pau_pkg::LIMIT_W-1:0]     high_lim_r;
  pau_pkg::gain_t                  min_gain_r;
  pau_pkg::gain_t                  max_gain_r;
  pau_pkg::cfg_idx_t               cfg_idx;
  logic                            cfg_wr;

  // Unpacker and word buffer
  logic [1:0]                      phase_r;
  logic [7:0]                      carry_r;
  pau_pkg::raw_t                   buf_r [3];
  logic [1:0]                      rem_r;
  logic [1:0]                      ph_eff;
  logic [1:0]                      phase_nxt;
  logic [7:0]                      carry_nxt;
  pau_pkg::raw_t                   unp [3];
  logic [1:0]                      n_nxt;
  pau_pkg::word_t                  w;
  logic                            in_acc;
  logic                            issue;
  logic                            adv;

  // Square stage
  logic                            b_v_r;
  pau_pkg::sample_t                b_x_r;
  logic                            b_over_r;
  logic [pau_pkg::SQ_W-1:0]        b_sq_r;
  logic                            b_last_r;
  pau_pkg::sample_t                head_x;
  logic signed [2*SW-1:0]          head_prod;
  logic                            head_over;

  // Statistics
  pau_pkg::count_t                 ovr_tot_r;
  pau_pkg::count_t                 clean_r;
  logic [EW-1:0]                   sum_r;
  logic [pau_pkg::WIN_W-1:0]       wc_r;
  pau_pkg::gain_t                  gain_r;
  pau_pkg::count_t                 ovr_tot_nxt;
  pau_pkg::count_t                 clean_nxt;
  logic [EW-1:0]                   sum_nxt;
  logic [pau_pkg::WIN_W-1:0]       wc_nxt;
  pau_pkg::gain_t                  gain_nxt;
  logic                            changed_nxt;
  logic [EW:0]                     sum_add;
  logic [EW-1:0]                   sum_sat;
  logic [pau_pkg::WIN_W-1:0]       wc_inc;
  logic signed [pau_pkg::GAIN_W+1:0] g_cur;
  logic signed [pau_pkg::GAIN_W+1:0] g_step;
  logic signed [pau_pkg::GAIN_W+1:0] g_min;
  logic signed [pau_pkg::GAIN_W+1:0] g_max;
  logic                            below_low;
  logic                            above_high;

  // Output register
  logic                            out_v_r;
  pau_pkg::sample_t                out_x_r;
  logic                            out_over_r;
  pau_pkg::count_t                 out_ovr_r;
  pau_pkg::count_t                 out_clean_r;
  pau_pkg::gain_t                  out_gain_r;
  logic                            out_chg_r;
  logic                            out_last_r;

  function automatic pau_pkg::sample_t sau_flip(input pau_pkg::raw_t raw);
    return pau_pkg::sample_t'({~raw[SW-1], raw[SW-2:0]});
  endfunction

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[pau_pkg::CFG_ADDR_W-1:pau_pkg::CFG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agc_en_r   <= 1'b1;
      win_len_r  <= pau_pkg::RST_WINDOW_LEN;
      low_lim_r  <= pau_pkg::RST_LOW_LIMIT;
      high_lim_r <= pau_pkg::RST_HIGH_LIMIT;
      min_gain_r <= pau_pkg::RST_MIN_GAIN;
      max_gain_r <= pau_pkg::RST_MAX_GAIN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pau_pkg::REG_AGC_ENABLE: agc_en_r   <= pwdata[0];
        pau_pkg::REG_WINDOW_LEN: win_len_r  <= pwdata[pau_pkg::WIN_W-1:0];
        pau_pkg::REG_LOW_LIMIT:  low_lim_r  <= pwdata[pau_pkg::LIMIT_W-1:0];
        pau_pkg::REG_HIGH_LIMIT: high_lim_r <= pwdata[pau_pkg::LIMIT_W-1:0];
        pau_pkg::REG_MIN_GAIN:   min_gain_r <= pwdata[pau_pkg::GAIN_W-1:0];
        pau_pkg::REG_MAX_GAIN:   max_gain_r <= pwdata[pau_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pau_pkg::REG_AGC_ENABLE: prdata = pau_pkg::CFG_DATA_W'(agc_en_r);
      pau_pkg::REG_WINDOW_LEN: prdata = pau_pkg::CFG_DATA_W'(win_len_r);
      pau_pkg::REG_LOW_LIMIT:  prdata = pau_pkg::CFG_DATA_W'(low_lim_r);
      pau_pkg::REG_HIGH_LIMIT: prdata = pau_pkg::CFG_DATA_W'(high_lim_r);
      pau_pkg::REG_MIN_GAIN:   prdata = pau_pkg::CFG_DATA_W'(min_gain_r);
      pau_pkg::REG_MAX_GAIN:   prdata = pau_pkg::CFG_DATA_W'(max_gain_r);
      default:                 prdata = '0;
    endcase
  end

  // Flow control
  assign adv            = !out_v_r || out_chan.ready;
  assign issue          = (rem_r != 2'd0) && (!b_v_r || adv);
  assign in_chan.ready  = (rem_r == 2'd0) || ((rem_r == 2'd1) && issue);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign w              = in_chan.packed_word;

  // Unpacking of one word according to the packing phase
  always_comb begin
    ph_eff = (in_chan.first_of_block || (phase_r == 2'd3)) ? pau_pkg::PHASE_0 : phase_r;
    unique case (ph_eff)
      pau_pkg::PHASE_1: begin
        unp[0]    = {carry_r, w[31:28]};
        unp[1]    = w[27:16];
        unp[2]    = w[15:4];
        n_nxt     = 2'd3;
        carry_nxt = {4'd0, w[3:0]};
        phase_nxt = pau_pkg::PHASE_2;
      end
      pau_pkg::PHASE_2: begin
        unp[0]    = {carry_r[3:0], w[31:24]};
        unp[1]    = w[23:12];
        unp[2]    = w[11:0];
        n_nxt     = 2'd3;
        carry_nxt = 8'd0;
        phase_nxt = pau_pkg::PHASE_0;
      end
      default: begin
        unp[0]    = w[31:20];
        unp[1]    = w[19:8];
        unp[2]    = '0;
        n_nxt     = 2'd2;
        carry_nxt = w[7:0];
        phase_nxt = pau_pkg::PHASE_1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pau_pkg::PHASE_0;
      carry_r <= 8'd0;
      rem_r   <= 2'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      rem_r   <= n_nxt;
    end else if (issue) begin
      rem_r   <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r[0] <= unp[0];
      buf_r[1] <= unp[1];
      buf_r[2] <= unp[2];
    end else if (issue) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  // Offset correction is an inversion of the sign bit
  assign head_x    = sau_flip(buf_r[0]);
  assign head_prod = head_x * head_x;
  assign head_over = (head_x == pau_pkg::RAIL_POS) || (head_x == pau_pkg::RAIL_NEG) ||
                     (head_x == pau_pkg::RAIL_NEG_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (!b_v_r || adv) begin
      b_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_x_r    <= head_x;
      b_over_r <= head_over;
      b_sq_r   <= head_prod[pau_pkg::SQ_W-1:0];
      b_last_r <= (rem_r == 2'd1);
    end
  end

  // Statistics and gain stepping for the sample in the square stage
  always_comb begin
    ovr_tot_nxt = ovr_tot_r;
    clean_nxt   = clean_r;
    sum_nxt     = sum_r;
    wc_nxt      = wc_r;
    gain_nxt    = gain_r;
    changed_nxt = 1'b0;
    sum_add     = (EW + 1)'(sum_r) + (EW + 1)'(b_sq_r);
    sum_sat     = sum_add[EW] ? '1 : sum_add[EW-1:0];
    wc_inc      = wc_r + 1'b1;
    below_low   = pau_pkg::CMP_W'(sum_sat) < pau_pkg::CMP_W'(low_lim_r);
    above_high  = pau_pkg::CMP_W'(sum_sat) > pau_pkg::CMP_W'(high_lim_r);
    g_cur       = $signed({2'b00, gain_r});
    g_min       = $signed({2'b00, min_gain_r});
    g_max       = $signed({2'b00, max_gain_r});
    g_step      = below_low ? g_cur + 7'sd1 : g_cur - 7'sd1;

    if (b_over_r) begin
      ovr_tot_nxt = ovr_tot_r + 1'b1;
      clean_nxt   = '0;
    end else if (clean_r != '1) begin
      clean_nxt   = clean_r + 1'b1;
    end

    if (agc_en_r) begin
      sum_nxt = sum_sat;
      wc_nxt  = wc_inc;
      if (wc_inc >= win_len_r) begin
        if (below_low || above_high) begin
          if (g_step < g_min) begin
            g_step = g_min;
          end else if (g_step > g_max) begin
            g_step = g_max;
          end
          gain_nxt    = g_step[pau_pkg::GAIN_W-1:0];
          changed_nxt = (g_step != g_cur);
        end
        sum_nxt = '0;
        wc_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      ovr_tot_r <= '0;
      clean_r   <= '0;
      sum_r     <= '0;
      wc_r      <= '0;
      gain_r    <= pau_pkg::RST_MAX_GAIN;
    end else if (adv) begin
      out_v_r <= b_v_r;
      if (b_v_r) begin
        ovr_tot_r <= ovr_tot_nxt;
        clean_r   <= clean_nxt;
        sum_r     <= sum_nxt;
        wc_r      <= wc_nxt;
        gain_r    <= gain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_v_r) begin
      out_x_r     <= b_x_r;
      out_over_r  <= b_over_r;
      out_ovr_r   <= ovr_tot_nxt;
      out_clean_r <= clean_nxt;
      out_gain_r  <= gain_nxt;
      out_chg_r   <= changed_nxt;
      out_last_r  <= b_last_r;
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.sample          = out_x_r;
  assign out_chan.overrange       = out_over_r;
  assign out_chan.overrange_count = out_ovr_r;
  assign out_chan.since_overrange = out_clean_r;
  assign out_chan.gain_step       = out_gain_r;
  assign out_chan.gain_changed    = out_chg_r;
  assign out_chan.last            = out_last_r;

endmodule
`default_nettype wire

### rtl/pau_checker.sv
`default_nettype none
module pau_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire pau_pkg::sample_t out_sample,
  input wire logic             out_overrange,
  input wire pau_pkg::count_t  out_since
);

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled transaction keeps its sample.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result changed");

  // The overrange flag marks exactly the rail values.
  a_rail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_overrange == ((out_sample == pau_pkg::RAIL_POS) ||
                                    (out_sample == pau_pkg::RAIL_NEG) ||
                                    (out_sample == pau_pkg::RAIL_NEG_MIN)))
    else $error("overrange flag disagrees with sample");

  // An overrange sample restarts the clean run, any other sample leaves it above zero.
  a_clean_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overrange == (out_since == '0)))
    else $error("clean run count inconsistent with overrange flag");

endmodule

bind packed_adc_unpack_with_agc pau_checker u_pau_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_sample    (out_chan.sample),
  .out_overrange (out_chan.overrange),
  .out_since     (out_chan.since_overrange)
);
`default_nettype wire

### tb/tb_packed_adc_unpack_with_agc.sv
`timescale 1ns / 100ps
module tb_packed_adc_unpack_with_agc;
  import pau_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

  typedef struct {
    sample_t sample;
    logic    overrange;
    count_t  overrange_count;
    count_t  since_overrange;
    gain_t   gain_step;
    logic    gain_changed;
    logic    last;
  } sample_rec_t;

  typedef struct packed {
    word_t                          word;
    logic                           fob;
    logic                           typed;
    logic [0:2][SAMPLE_W-1:0]       s;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pau_in_if  in_if ();
  pau_out_if out_if ();

  packed_adc_unpack_with_agc dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Register image as the block should hold it.
  logic                 agc_en;
  logic [WIN_W-1:0]     win_len;
  logic [LIMIT_W-1:0]   low_lim;
  logic [LIMIT_W-1:0]   high_lim;
  gain_t                min_gain;
  gain_t                max_gain;

  // Unpacker and AGC state.
  logic [1:0]             phase_q;
  logic [7:0]             carry_q;
  count_t                 ovr_total;
  count_t                 clean_run;
  logic [ENERGY_BITS-1:0] energy_acc;
  logic [WIN_W-1:0]       win_cnt;
  gain_t                  gain_idx;

  sample_rec_t pending_samples[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int          rx_hold = 0;

  stim_row_t directed_rows [0:12] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{RAIL_NEG_MIN, RAIL_NEG_MIN, 12'sd0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{-12'sd2033, RAIL_POS, RAIL_POS}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{RAIL_POS, RAIL_POS, RAIL_POS}},
    '{32'h8008_0000, 1'b0, 1'b1, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'h0800_8000, 1'b0, 1'b1, '{RAIL_NEG_MIN, 12'sd0, 12'sd0}},
    '{32'h01FF_E002, 1'b0, 1'b1, '{RAIL_NEG, 12'sd2046, -12'sd2046}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{RAIL_POS, RAIL_POS, 12'sd0}},
    '{32'h1234_5678, 1'b1, 1'b0, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'hA5A5_A5A5, 1'b0, 1'b0, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'h5A5A_5A5A, 1'b1, 1'b0, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'h0000_0000, 1'b0, 1'b0, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'h7FF8_00FF, 1'b0, 1'b0, '{12'sd0, 12'sd0, 12'sd0}},
    '{32'h0010_0100, 1'b1, 1'b1, '{RAIL_NEG, RAIL_NEG, 12'sd0}}
  };

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      flag_error($sformatf("%s expected %0h, got %0h", name, want, got));
    end
  endfunction

  function automatic void emit_sample(input logic [SAMPLE_W-1:0] raw, input logic is_last);
    int          x;
    int          g;
    logic        over;
    logic        changed;
    logic        stepped;
    logic [64:0] sum;
    sample_rec_t r;
    x = int'(raw) - 2048;
    over = (x == 2047) || (x <= -2047);
    changed = 1'b0;
    if (over) begin
      ovr_total++;
      clean_run = '0;
    end else if (clean_run != '1) begin
      clean_run++;
    end
    if (agc_en) begin
      sum = 65'(energy_acc) + 65'(x * x);
      energy_acc = (sum > 65'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_BITS-1:0];
      win_cnt++;
      if (win_cnt >= win_len) begin
        g = int'(gain_idx);
        stepped = 1'b0;
        if (energy_acc < low_lim) begin
          g++;
          stepped = 1'b1;
        end else if (energy_acc > high_lim) begin
          g--;
          stepped = 1'b1;
        end
        if (stepped) begin
          if (g < int'(min_gain)) begin
            g = int'(min_gain);
          end else if (g > int'(max_gain)) begin
            g = int'(max_gain);
          end
          if (g != int'(gain_idx)) begin
            gain_idx = gain_t'(g);
            changed = 1'b1;
          end
        end
        energy_acc = '0;
        win_cnt = '0;
      end
    end
    r.sample = sample_t'(x);
    r.overrange = over;
    r.overrange_count = ovr_total;
    r.since_overrange = clean_run;
    r.gain_step = gain_idx;
    r.gain_changed = changed;
    r.last = is_last;
    pending_samples.push_back(r);
  endfunction

  function automatic int unpack_word(input word_t w, input logic fob);
    logic [1:0] ph;
    ph = (fob || phase_q > PHASE_2) ? PHASE_0 : phase_q;
    case (ph)
      PHASE_0: begin
        emit_sample(w[31:20], 1'b0);
        emit_sample(w[19:8], 1'b1);
        carry_q = w[7:0];
        phase_q = PHASE_1;
        return 2;
      end
      PHASE_1: begin
        emit_sample({carry_q, w[31:28]}, 1'b0);
        emit_sample(w[27:16], 1'b0);
        emit_sample(w[15:4], 1'b1);
        carry_q = {4'b0, w[3:0]};
        phase_q = PHASE_2;
        return 3;
      end
      default: begin
        emit_sample({carry_q[3:0], w[31:24]}, 1'b0);
        emit_sample(w[23:12], 1'b0);
        emit_sample(w[11:0], 1'b1);
        carry_q = '0;
        phase_q = PHASE_0;
        return 3;
      end
    endcase
  endfunction

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_image(input cfg_idx_t idx);
    case (idx)
      REG_AGC_ENABLE: return CFG_DATA_W'(agc_en);
      REG_WINDOW_LEN: return CFG_DATA_W'(win_len);
      REG_LOW_LIMIT:  return CFG_DATA_W'(low_lim);
      REG_HIGH_LIMIT: return CFG_DATA_W'(high_lim);
      REG_MIN_GAIN:   return CFG_DATA_W'(min_gain);
      default:        return CFG_DATA_W'(max_gain);
    endcase
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8008_0080 ^ ($urandom & 32'h0030_0303);
      3:       return $urandom | 32'hFFF0_0FFF;
      4:       return $urandom & 32'h0010_0F00;
      default: return $urandom;
    endcase
  endfunction

  task automatic apb_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, {CFG_IDX_LSB{1'b0}}};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_AGC_ENABLE: agc_en = val[0];
      REG_WINDOW_LEN: win_len = val[WIN_W-1:0];
      REG_LOW_LIMIT:  low_lim = val[LIMIT_W-1:0];
      REG_HIGH_LIMIT: high_lim = val[LIMIT_W-1:0];
      REG_MIN_GAIN:   min_gain = val[GAIN_W-1:0];
      REG_MAX_GAIN:   max_gain = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    cfg_idx_t idx;
    for (int i = 0; i <= int'(REG_MAX_GAIN); i++) begin
      idx = cfg_idx_t'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, {CFG_IDX_LSB{1'b0}}};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      compare_field($sformatf("register %0d read", i), reg_image(idx), prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] win,
                          input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                          input logic [CFG_DATA_W-1:0] mn, input logic [CFG_DATA_W-1:0] mx);
    apb_write(REG_AGC_ENABLE, en);
    apb_write(REG_WINDOW_LEN, win);
    apb_write(REG_LOW_LIMIT, lo);
    apb_write(REG_HIGH_LIMIT, hi);
    apb_write(REG_MIN_GAIN, mn);
    apb_write(REG_MAX_GAIN, mx);
    check_regs();
  endtask

  task automatic send_word(input word_t w, input logic fob, output int n);
    in_if.valid <= 1'b1;
    in_if.packed_word <= w;
    in_if.first_of_block <= fob;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n = unpack_word(w, fob);
  endtask

  task automatic sender_gap();
    int gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int   n;
    logic fob;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
      end
      if (phase_q == PHASE_0) begin
        fob = ($urandom_range(0, 9) != 0);
      end else begin
        fob = ($urandom_range(0, 9) == 0);
      end
      send_word(random_word(), fob, n);
      sender_gap();
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_if.ready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
      rx_hold = idle_len() - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sample_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        flag_error($sformatf("unexpected sample %0h", out_if.sample));
      end else begin
        want = pending_samples.pop_front();
        compare_field("sample", want.sample, out_if.sample);
        compare_field("overrange", want.overrange, out_if.overrange);
        compare_field("overrange_count", want.overrange_count, out_if.overrange_count);
        compare_field("since_overrange", want.since_overrange, out_if.since_overrange);
        compare_field("gain_step", want.gain_step, out_if.gain_step);
        compare_field("gain_changed", want.gain_changed, out_if.gain_changed);
        compare_field("last", want.last, out_if.last);
      end
    end
  end

  initial begin
    int n;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.packed_word = '0;
    in_if.first_of_block = 1'b0;
    out_if.ready = 1'b0;
    agc_en = 1'b1;
    win_len = RST_WINDOW_LEN;
    low_lim = RST_LOW_LIMIT;
    high_lim = RST_HIGH_LIMIT;
    min_gain = RST_MIN_GAIN;
    max_gain = RST_MAX_GAIN;
    phase_q = PHASE_0;
    carry_q = '0;
    ovr_total = '0;
    clean_run = '0;
    energy_acc = '0;
    win_cnt = '0;
    gain_idx = RST_MAX_GAIN;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].fob, n);
      if (directed_rows[i].typed) begin
        for (int k = 0; k < n; k++) begin
          compare_field($sformatf("directed row %0d sample %0d", i, k),
                        sample_t'(directed_rows[i].s[k]),
                        pending_samples[pending_samples.size() - n + k].sample);
        end
      end
      sender_gap();
    end

    // A window of one sample with both limits at zero steps the gain down.
    drain();
    set_regs(64'd1, 64'd1, 64'd0, 64'd0, 64'd0, 64'd31);
    run_random(40);

    // Zero window, inverted limits and no idling on either side.
    drain();
    set_regs(64'd1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd3, 64'd31);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    for (int i = 0; i < 25; i++) begin
      send_word(random_word(), phase_q == PHASE_0, n);
    end

    // Minimum above maximum, so a step below the minimum lands on the minimum and any other on the maximum.
    drain();
    set_regs(64'd1, 64'd3, 64'd3_000_000, 64'd6_000_000, 64'd20, 64'd10);
    run_random(40);

    // AGC off with the low limit at zero and every other register at its top value.
    drain();
    set_regs(64'hFFFF_FFFF_FFFF_FFFE, '1, 64'd0, '1, '1, '1);
    run_random(25);

    drain();
    set_regs(64'd1, 64'hABCD_0000_0000_0005, 64'd5_000_000, 64'd10_000_000, 64'd0, 64'd21);
    run_random(70);

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
